// ===== rtl/core/mcb_pkg.sv =====
// mcb_pkg: constants, command codes, operation and state types of the MIB counter bank.
// Used by every RTL file of the block but mcb_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mcb_pkg;

  localparam int NUM_IFACES     = 4;
  localparam int GLOBAL_COUNT   = 100;
  localparam int IFACE_COUNT    = 13;
  localparam int ESTAB_GAUGE_ID = 90;
  localparam int SPEED_GAUGE_ID = 0;
  localparam int QLEN_GAUGE_ID  = 12;

  localparam int CMD_W      = 3;
  localparam int IDX_W      = 8;
  localparam int DATA_W     = 32;
  localparam int IFACE_CELLS = NUM_IFACES * IFACE_COUNT;
  localparam int MEM_DEPTH  = GLOBAL_COUNT + IFACE_CELLS;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_BUMP     = 3'd1,
    CMD_SET      = 3'd2,
    CMD_READ     = 3'd3,
    CMD_IF_BUMP  = 3'd4,
    CMD_IF_SET   = 3'd5,
    CMD_IF_READ  = 3'd6,
    CMD_RSVD     = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ADD,
    OP_SET,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic              legal;
    logic [ADDR_W-1:0] addr;
  } mcb_op_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
  } mcb_ram_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/mcb_ifs.sv =====
// mcb_ifs: valid/ready channel interfaces for command words and result words.
// Depends on mcb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mcb_in_if
  import mcb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [IDX_W-1:0]  iface;
  logic [IDX_W-1:0]  counter_id;
  logic [DATA_W-1:0] write_value;

  modport source (output valid, output cmd, output iface, output counter_id,
                  output write_value, input ready);
  modport sink   (input valid, input cmd, input iface, input counter_id,
                  input write_value, output ready);
endinterface

interface mcb_out_if
  import mcb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_value;
  logic              status;

  modport source (output valid, output read_value, output status, input ready);
  modport sink   (input valid, input read_value, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mib_counter_bank.sv =====
// mib_counter_bank: top level of the MIB statistics counter bank.
// Depends on mcb_pkg, mcb_ifs, mcb_ram, mcb_decode and mcb_engine.
//
// Usage:
//   in_ch  carries command words (cmd, iface, counter_id, write_value) on a
//          valid/ready handshake; out_ch returns one result word per command
//          (read_value = held reported value, status = 1 when refused).
//   All counters live in one 152 x 32 synchronous RAM: global counters at
//   0..99, interface rows above them at 100 + iface * 13 + counter_id.
//   Bump, set and read first read the RAM, then modify, write back and load
//   the result register; the RAM's registered read data sets this order.
//   Clear sweeps every RAM entry, one per cycle, then waits for the result
//   register to free before it answers.
//   Reset leaves the store unbound: every command but clear answers error
//   until a clear has run. Counter contents are undefined until that clear.
//   A new command word is taken while a result word still waits; if out_ch
//   stalls, the following command holds in its last step until the result
//   register frees.
`timescale 1ns / 1ps
`default_nettype none
module mib_counter_bank
  import mcb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mcb_in_if.sink    in_ch,
  mcb_out_if.source out_ch
);

  mcb_op_t           op;
  mcb_ram_req_t      ram_req;
  logic [DATA_W-1:0] ram_rdata;

  mcb_decode u_decode (
    .cmd        (in_ch.cmd),
    .iface      (in_ch.iface),
    .counter_id (in_ch.counter_id),
    .op         (op)
  );

  mcb_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_op      (op),
    .in_value   (in_ch.write_value),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_value  (out_ch.read_value),
    .out_status (out_ch.status)
  );

  mcb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/core/mcb_ram.sv =====
// mcb_ram: generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mcb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mcb_decode.sv =====
// mcb_decode: maps a command word to an operation kind, range/gauge legality and
// a flat memory address. Depends on mcb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcb_decode
  import mcb_pkg::*;
(
  input  wire logic [CMD_W-1:0] cmd,
  input  wire logic [IDX_W-1:0] iface,
  input  wire logic [IDX_W-1:0] counter_id,
  output      mcb_op_t          op
);

  logic              gidx;
  logic              iidx;
  logic              g_gauge;
  logic              i_gauge;
  logic [ADDR_W-1:0] gaddr;
  logic [ADDR_W-1:0] iaddr;

  always_comb begin
    gidx    = counter_id < IDX_W'(GLOBAL_COUNT);
    iidx    = (iface < IDX_W'(NUM_IFACES)) && (counter_id < IDX_W'(IFACE_COUNT));
    g_gauge = counter_id == IDX_W'(ESTAB_GAUGE_ID);
    i_gauge = (counter_id == IDX_W'(SPEED_GAUGE_ID)) ||
              (counter_id == IDX_W'(QLEN_GAUGE_ID));
    gaddr   = ADDR_W'(counter_id);
    // interface rows sit above the global block
    iaddr   = ADDR_W'(GLOBAL_COUNT) + ADDR_W'(iface) * ADDR_W'(IFACE_COUNT)
              + ADDR_W'(counter_id);

    op.kind  = OP_NONE;
    op.legal = 1'b0;
    op.addr  = gaddr;
    unique case (cmd_t'(cmd))
      CMD_CLEAR: begin
        op.kind  = OP_CLEAR;
        op.legal = 1'b1;
      end
      CMD_BUMP: begin
        op.kind  = OP_ADD;
        op.legal = gidx && !g_gauge;
      end
      CMD_SET: begin
        op.kind  = OP_SET;
        op.legal = gidx && g_gauge;
      end
      CMD_READ: begin
        op.kind  = OP_READ;
        op.legal = gidx;
      end
      CMD_IF_BUMP: begin
        op.kind  = OP_ADD;
        op.legal = iidx && !i_gauge;
        op.addr  = iaddr;
      end
      CMD_IF_SET: begin
        op.kind  = OP_SET;
        op.legal = iidx && i_gauge;
        op.addr  = iaddr;
      end
      CMD_IF_READ: begin
        op.kind  = OP_READ;
        op.legal = iidx;
        op.addr  = iaddr;
      end
      default: begin
        op.kind  = OP_NONE;
        op.legal = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/mcb_engine.sv =====
// mcb_engine: command sequencer; memory read-modify-write, clear sweep, bound flag,
// held value and the result register. Depends on mcb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcb_engine
  import mcb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire mcb_op_t           in_op,
  input  wire logic [DATA_W-1:0] in_value,
  output      mcb_ram_req_t      ram_req,
  input  wire logic [DATA_W-1:0] ram_rdata,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [DATA_W-1:0] out_value,
  output      logic              out_status
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);

  state_t            st_r, st_nxt;
  mcb_op_t           op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              bound_r, bound_nxt;
  logic [DATA_W-1:0] held_r, held_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_status_r, out_status_nxt;
  logic              accept;
  logic              load_ok;
  logic              ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      bound_r     <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      bound_r     <= bound_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    clr_r        <= clr_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    in_ready       = st_r == ST_IDLE;
    accept         = in_valid && in_ready;
    load_ok        = !out_valid_r || out_ready;
    ok             = op_r.legal && bound_r;

    st_nxt         = st_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    clr_nxt        = clr_r;
    bound_nxt      = bound_r;
    held_nxt       = held_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    ram_req.re     = accept;
    ram_req.raddr  = in_op.addr;
    ram_req.we     = 1'b0;
    ram_req.waddr  = op_r.addr;
    ram_req.wdata  = val_r;

    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt  = in_op;
          val_nxt = in_value;
          clr_nxt = '0;
          st_nxt  = (in_op.kind == OP_CLEAR) ? ST_CLEAR : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (load_ok) begin
          case (op_r.kind)
            OP_ADD: begin
              ram_req.we    = ok;
              ram_req.wdata = ram_rdata + val_r;
            end
            OP_SET: begin
              ram_req.we    = ok;
              ram_req.wdata = val_r;
            end
            OP_READ: begin
              held_nxt = ok ? ram_rdata : '0;
            end
            default: begin
            end
          endcase
          out_valid_nxt  = 1'b1;
          out_value_nxt  = held_nxt;
          out_status_nxt = !ok;
          st_nxt         = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_r;
        ram_req.wdata = '0;
        if (clr_r != LAST_ADDR) begin
          clr_nxt = clr_r + 1'b1;
        end else if (load_ok) begin
          held_nxt       = '0;
          bound_nxt      = 1'b1;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = 1'b0;
          st_nxt         = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    out_valid  = out_valid_r;
    out_value  = out_value_r;
    out_status = out_status_r;
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r == ST_IDLE && ram_req.we))
    else $error("memory write while idle");

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op.kind != OP_CLEAR) |=> st_r == ST_EXEC)
    else $error("accepted word did not enter execute");

  a_bound_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    bound_r |=> bound_r)
    else $error("bound flag dropped without reset");

  a_write_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.we && st_r == ST_EXEC) |-> (op_r.legal && bound_r))
    else $error("refused command wrote a counter");
`endif

endmodule
`default_nettype wire

// ===== sim/mib_counter_bank_tb.sv =====
// mib_counter_bank_tb: self-checking bench for the MIB counter bank; a scoreboard model of
// the counter store predicts every result word, random gaps stall both channels.
// Depends on mcb_pkg, mcb_ifs and the mib_counter_bank RTL.
`timescale 1ns / 1ps
module mib_counter_bank_tb;
  import mcb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_WORDS   = 1450;
  localparam int GIDX_W         = $clog2(GLOBAL_COUNT);
  localparam int IIDX_W         = $clog2(IFACE_CELLS);

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              status;
  } counter_resp_t;

  logic clk;
  logic rst_n;

  mcb_in_if  cmd_ch ();
  mcb_out_if res_ch ();

  mib_counter_bank dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  // scoreboard copy of the store
  logic [DATA_W-1:0] bank_glob [GLOBAL_COUNT];
  logic [DATA_W-1:0] bank_ifc  [IFACE_CELLS];
  logic              bank_bound;
  logic [DATA_W-1:0] bank_held;

  counter_resp_t pending_resp[$];
  int            mismatches;
  int            idle_cycles;
  int            in_mode;
  int            out_mode;
  int            stall_left;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int gap_len(input int mode);
    int r;
    int zero_pct;
    if (mode == 0) return 0;
    zero_pct = (mode == 1) ? 85 : 55;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic counter_resp_t predict_response(input cmd_t c, input logic [IDX_W-1:0] ifc,
                                                     input logic [IDX_W-1:0] id,
                                                     input logic [DATA_W-1:0] v);
    counter_resp_t r;
    logic gidx;
    logic iidx;
    logic ggauge;
    logic igauge;
    logic [GIDX_W-1:0] gslot;
    logic [IIDX_W-1:0] slot;
    gidx   = id < GLOBAL_COUNT;
    iidx   = (ifc < NUM_IFACES) && (id < IFACE_COUNT);
    ggauge = id == ESTAB_GAUGE_ID;
    igauge = (id == SPEED_GAUGE_ID) || (id == QLEN_GAUGE_ID);
    gslot  = GIDX_W'(id);
    slot   = iidx ? IIDX_W'(int'(ifc) * IFACE_COUNT + int'(id)) : '0;
    r.status = 1'b1;
    case (c)
      CMD_CLEAR: begin
        foreach (bank_glob[i]) bank_glob[i] = '0;
        foreach (bank_ifc[i]) bank_ifc[i] = '0;
        bank_held  = '0;
        bank_bound = 1'b1;
        r.status   = 1'b0;
      end
      CMD_BUMP: if (bank_bound && gidx && !ggauge) begin
        bank_glob[gslot] = bank_glob[gslot] + v;
        r.status = 1'b0;
      end
      CMD_SET: if (bank_bound && gidx && ggauge) begin
        bank_glob[gslot] = v;
        r.status = 1'b0;
      end
      CMD_READ: begin
        bank_held = '0;
        if (bank_bound && gidx) begin
          bank_held = bank_glob[gslot];
          r.status = 1'b0;
        end
      end
      CMD_IF_BUMP: if (bank_bound && iidx && !igauge) begin
        bank_ifc[slot] = bank_ifc[slot] + v;
        r.status = 1'b0;
      end
      CMD_IF_SET: if (bank_bound && iidx && igauge) begin
        bank_ifc[slot] = v;
        r.status = 1'b0;
      end
      CMD_IF_READ: begin
        bank_held = '0;
        if (bank_bound && iidx) begin
          bank_held = bank_ifc[slot];
          r.status = 1'b0;
        end
      end
      default: ;
    endcase
    r.value = bank_held;
    return r;
  endfunction

  task automatic send_word(input cmd_t c, input logic [IDX_W-1:0] ifc,
                           input logic [IDX_W-1:0] id, input logic [DATA_W-1:0] v);
    int gap;
    gap = gap_len(in_mode);
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid       = 1'b1;
    cmd_ch.cmd         = c;
    cmd_ch.iface       = ifc;
    cmd_ch.counter_id  = id;
    cmd_ch.write_value = v;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_resp.push_back(predict_response(c, ifc, id, v));
  endtask

  task automatic release_input();
    @(negedge clk);
    cmd_ch.valid = 1'b0;
  endtask

  // result side: random backpressure
  always @(negedge clk) begin
    int n;
    if (stall_left > 0) begin
      res_ch.ready = 1'b0;
      stall_left--;
    end else begin
      n = gap_len(out_mode);
      if (n > 0) begin
        res_ch.ready = 1'b0;
        stall_left = n - 1;
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    counter_resp_t exp_r;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: value=%h status=%b",
                   res_ch.read_value, res_ch.status);
      end else begin
        exp_r = pending_resp.pop_front();
        if (res_ch.read_value !== exp_r.value || res_ch.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%h status=%b, got value=%h status=%b",
                     exp_r.value, exp_r.status, res_ch.read_value, res_ch.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic test_unbound();
    in_mode  = 1;
    out_mode = 1;
    send_word(CMD_READ, 8'd0, 8'd0, 32'h0);
    send_word(CMD_BUMP, 8'd0, 8'd1, 32'h5);
    send_word(CMD_SET, 8'd0, IDX_W'(ESTAB_GAUGE_ID), 32'h1234);
    send_word(CMD_IF_BUMP, 8'd1, 8'd1, 32'h7);
    send_word(CMD_IF_SET, 8'd0, IDX_W'(SPEED_GAUGE_ID), 32'h9);
    send_word(CMD_IF_READ, 8'd0, 8'd1, 32'h0);
    send_word(CMD_RSVD, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    in_mode  = 1;
    out_mode = 2;
    send_word(CMD_CLEAR, 8'd0, 8'd0, 32'h0);
    send_word(CMD_BUMP, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_word(CMD_BUMP, 8'd0, 8'd0, 32'h2);          // wrap
    send_word(CMD_READ, 8'd0, 8'd0, 32'h0);
    send_word(CMD_BUMP, 8'd0, IDX_W'(GLOBAL_COUNT - 1), 32'hA5A5_5A5A);
    send_word(CMD_READ, 8'd0, IDX_W'(GLOBAL_COUNT - 1), 32'h0);
    send_word(CMD_BUMP, 8'd0, 8'd7, 32'h1);          // held value unchanged
    send_word(CMD_SET, 8'd0, IDX_W'(ESTAB_GAUGE_ID), 32'hDEAD_BEEF);
    send_word(CMD_BUMP, 8'd0, IDX_W'(ESTAB_GAUGE_ID), 32'h1); // gauge refuses bump
    send_word(CMD_SET, 8'd0, 8'd5, 32'h1);           // counter refuses set
    send_word(CMD_READ, 8'd0, IDX_W'(ESTAB_GAUGE_ID), 32'h0);
    send_word(CMD_READ, 8'd0, IDX_W'(GLOBAL_COUNT), 32'h0);  // out of range, held zeroed
    send_word(CMD_BUMP, 8'hFF, 8'hFF, 32'h1);
    send_word(CMD_IF_BUMP, IDX_W'(NUM_IFACES - 1), IDX_W'(IFACE_COUNT - 2), 32'hFFFF_FFFF);
    send_word(CMD_IF_SET, 8'd0, IDX_W'(SPEED_GAUGE_ID), 32'h0001_0000);
    send_word(CMD_IF_SET, IDX_W'(NUM_IFACES - 1), IDX_W'(QLEN_GAUGE_ID), 32'hFFFF_FFFF);
    send_word(CMD_IF_BUMP, 8'd2, IDX_W'(SPEED_GAUGE_ID), 32'h1);
    send_word(CMD_IF_SET, 8'd2, 8'd5, 32'h1);
    send_word(CMD_IF_READ, IDX_W'(NUM_IFACES), 8'd1, 32'h0);
    send_word(CMD_IF_READ, 8'd1, IDX_W'(IFACE_COUNT), 32'h0);
    send_word(CMD_IF_READ, IDX_W'(NUM_IFACES - 1), IDX_W'(QLEN_GAUGE_ID), 32'h0);
    send_word(CMD_IF_READ, IDX_W'(NUM_IFACES - 1), IDX_W'(IFACE_COUNT - 2), 32'h0);
    send_word(CMD_IF_BUMP, 8'hFF, 8'hFF, 32'h0);
    send_word(CMD_RSVD, 8'h00, 8'h00, 32'h0);
    send_word(CMD_CLEAR, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_word(CMD_READ, 8'd0, IDX_W'(ESTAB_GAUGE_ID), 32'h0);
  endtask

  task automatic test_random_traffic(input int count, input int imode, input int omode);
    cmd_t c;
    logic [IDX_W-1:0] ifc;
    logic [IDX_W-1:0] id;
    logic [DATA_W-1:0] v;
    int r;
    in_mode  = imode;
    out_mode = omode;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 2) c = CMD_CLEAR;
      else if (r < 5) c = CMD_RSVD;
      else c = cmd_t'($urandom_range(1, 6));
      r = $urandom_range(0, 99);
      if (r < 85) ifc = IDX_W'($urandom_range(0, NUM_IFACES - 1));
      else if (r < 90) ifc = IDX_W'(NUM_IFACES);
      else ifc = IDX_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (c == CMD_SET || c == CMD_READ || c == CMD_BUMP) begin
        if (r < ((c == CMD_SET) ? 70 : 15)) id = IDX_W'(ESTAB_GAUGE_ID);
        else if (r < 90) id = IDX_W'($urandom_range(0, GLOBAL_COUNT - 1));
        else id = IDX_W'($urandom_range(0, 255));
      end else begin
        if (r < ((c == CMD_IF_SET) ? 70 : 15))
          id = IDX_W'($urandom_range(0, 1) ? SPEED_GAUGE_ID : QLEN_GAUGE_ID);
        else if (r < 90) id = IDX_W'($urandom_range(0, IFACE_COUNT - 1));
        else id = IDX_W'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 99);
      if (r < 10) v = 32'hFFFF_FFFF;
      else if (r < 20) v = '0;
      else if (r < 35) v = $urandom_range(0, 255);
      else v = $urandom;
      send_word(c, ifc, id, v);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.cmd         = '0;
    cmd_ch.iface       = '0;
    cmd_ch.counter_id  = '0;
    cmd_ch.write_value = '0;
    in_mode            = 0;
    out_mode           = 0;
    bank_bound         = 1'b0;
    bank_held          = '0;
    foreach (bank_glob[i]) bank_glob[i] = '0;
    foreach (bank_ifc[i]) bank_ifc[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_unbound();
    test_directed();
    test_random_traffic(RANDOM_WORDS / 4, 0, 0);
    test_random_traffic(RANDOM_WORDS / 4, 1, 1);
    test_random_traffic(RANDOM_WORDS / 4, 2, 2);
    test_random_traffic(RANDOM_WORDS / 8, 0, 2);
    test_random_traffic(RANDOM_WORDS / 8, 2, 0);
    release_input();

    while (pending_resp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== mib_counter_bank.f =====
rtl/core/mcb_pkg.sv
rtl/core/mcb_ifs.sv
rtl/core/mcb_ram.sv
rtl/core/mcb_decode.sv
rtl/core/mcb_engine.sv
rtl/core/mib_counter_bank.sv
sim/mib_counter_bank_tb.sv
